// ===== hw/rtl/vlc_pkg.sv =====
`timescale 1ns / 1ps

package vlc_pkg;

  // Key geometry.
  localparam int KEY_CHARS   = 16;
  localparam int KEY_IDX_W   = 4;
  localparam int KEY_LEN_W   = 5;
  localparam int KEY_WORD_W  = 64;
  localparam int BYTES_PER_W = 8;

  // Payload and configuration widths.
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_LOWER = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_UPPER = 8'd3;

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [5:0]        ALPHABET_SIZE = 6'd26;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_text;
    logic lookup;
    logic apply;
  } vlc_cmd_t;

endpackage

// ===== hw/rtl/vlc_ctrl.sv =====
`timescale 1ns / 1ps

module vlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vlc_pkg::vlc_cmd_t cmd
);
  import vlc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_APPLY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;
  logic   in_acc;

  // The output register can take a new result when it is empty or being drained.
  assign load_ok  = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_APPLY) && load_ok);
  assign in_acc   = in_valid && in_ready;

  assign cmd.load_text = in_acc;
  assign cmd.lookup    = (state_r == ST_LOOKUP);
  assign cmd.apply     = (state_r == ST_APPLY) && load_ok;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_acc ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_apply_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid_r)
    else $error("result not presented after apply");

  a_lookup_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |=> (state_r == ST_APPLY))
    else $error("lookup not followed by apply");

  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LOOKUP))
    else $error("accepted item did not start a lookup");

  a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |-> !in_ready)
    else $error("input ready while an item is in lookup");

endmodule

// ===== hw/rtl/vlc_datapath.sv =====
`timescale 1ns / 1ps

module vlc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vlc_pkg::vlc_cmd_t                   cmd,
  input  logic [vlc_pkg::BYTE_W-1:0]          in_text_byte,
  input  logic                                cfg_write,
  input  logic [vlc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vlc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [vlc_pkg::BYTE_W-1:0]          out_result_byte,
  output logic                                out_no_key_letter
);
  import vlc_pkg::*;

  function automatic logic is_upper(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
  endfunction

  function automatic logic is_lower(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
  endfunction

  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  // Remainder of a 4-bit position by a nonzero length, four restoring steps.
  function automatic logic [KEY_IDX_W-1:0] pos_mod(input logic [KEY_IDX_W-1:0] p,
                                                   input logic [KEY_LEN_W-1:0] l);
    logic [8:0] r;
    logic [8:0] d;
    r = {5'b0, p};
    for (int s = KEY_IDX_W - 1; s >= 0; s--) begin
      d = {4'b0, l} << s;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[KEY_IDX_W-1:0];
  endfunction

  // Lowest set bit: {found, index}.
  function automatic logic [KEY_IDX_W:0] first_set(input logic [KEY_CHARS-1:0] m);
    logic [KEY_IDX_W:0] res;
    res = '0;
    for (int i = KEY_CHARS - 1; i >= 0; i--) begin
      if (m[i]) begin
        res = {1'b1, KEY_IDX_W'(i)};
      end
    end
    return res;
  endfunction

  // Configuration and key state.
  logic [KEY_LEN_W-1:0]  key_length_r;
  logic                  decrypt_r;
  logic [KEY_WORD_W-1:0] key_lo_r;
  logic [KEY_WORD_W-1:0] key_hi_r;
  logic [KEY_IDX_W-1:0]  key_pos_r, key_pos_nxt;

  // Item registers.
  logic [BYTE_W-1:0]     text_r;
  logic [KEY_IDX_W-1:0]  sel_pos_r;
  logic                  found_r;
  logic                  empty_r;
  logic [BYTE_W-1:0]     result_r, result_nxt;
  logic                  flag_r, flag_nxt;

  logic [BYTE_W-1:0]     kb [KEY_CHARS];
  logic [KEY_LEN_W-1:0]  len;
  logic [KEY_IDX_W-1:0]  pos_m;
  logic [KEY_CHARS-1:0]  letter_mask;
  logic [KEY_CHARS-1:0]  ge_mask;
  logic [KEY_IDX_W:0]    hit_hi;
  logic [KEY_IDX_W:0]    hit_any;
  logic [KEY_IDX_W:0]    hit;

  logic [BYTE_W-1:0]     k;
  logic [4:0]            rot;
  logic [BYTE_W-1:0]     base;
  logic [4:0]            off;
  logic [5:0]            sum;
  logic [5:0]            sum_red;
  logic [BYTE_W-1:0]     shifted;

  always_comb begin
    for (int i = 0; i < BYTES_PER_W; i++) begin
      kb[i]               = key_lo_r[i*BYTE_W +: BYTE_W];
      kb[i + BYTES_PER_W] = key_hi_r[i*BYTE_W +: BYTE_W];
    end
  end

  // Lookup: find the next key letter at or after the (reduced) position, wrapping.
  always_comb begin
    len = (key_length_r > KEY_LEN_W'(KEY_CHARS)) ? KEY_LEN_W'(KEY_CHARS) : key_length_r;
    pos_m = pos_mod(key_pos_r, len);
    for (int i = 0; i < KEY_CHARS; i++) begin
      letter_mask[i] = is_letter(kb[i]) && (KEY_LEN_W'(i) < len);
      ge_mask[i]     = (KEY_IDX_W'(i) >= pos_m);
    end
    hit_hi  = first_set(letter_mask & ge_mask);
    hit_any = first_set(letter_mask);
    hit     = hit_hi[KEY_IDX_W] ? hit_hi : hit_any;
  end

  // Apply: shift the text letter by the selected key letter.
  always_comb begin
    k    = kb[sel_pos_r];
    rot  = is_lower(k) ? 5'(k - CHAR_LOWER_A) : 5'(k - CHAR_UPPER_A);
    base = is_upper(text_r) ? CHAR_UPPER_A : CHAR_LOWER_A;
    off  = 5'(text_r - base);
    if (decrypt_r) begin
      sum = {1'b0, off} + ALPHABET_SIZE - {1'b0, rot};
    end else begin
      sum = {1'b0, off} + {1'b0, rot};
    end
    sum_red = (sum >= ALPHABET_SIZE) ? (sum - ALPHABET_SIZE) : sum;
    shifted = base + {3'b0, sum_red[4:0]};

    result_nxt  = text_r;
    flag_nxt    = 1'b0;
    key_pos_nxt = key_pos_r;
    if (!empty_r) begin
      if (!found_r) begin
        flag_nxt = 1'b1;
      end else if (is_letter(text_r)) begin
        result_nxt  = shifted;
        key_pos_nxt = (({1'b0, sel_pos_r} + 5'd1) == len) ? '0 : (sel_pos_r + 4'd1);
      end else begin
        // The key letter found is kept for the next text letter.
        key_pos_nxt = sel_pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= '0;
      decrypt_r    <= 1'b0;
      key_lo_r     <= '0;
      key_hi_r     <= '0;
      key_pos_r    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_KEY_LENGTH:      key_length_r <= cfg_data[KEY_LEN_W-1:0];
          REG_DECRYPT_MODE:    decrypt_r    <= cfg_data[0];
          REG_KEY_BYTES_LOWER: key_lo_r     <= cfg_data;
          REG_KEY_BYTES_UPPER: key_hi_r     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.apply) begin
        key_pos_r <= key_pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_text) begin
      text_r <= in_text_byte;
    end
    if (cmd.lookup) begin
      sel_pos_r <= hit[KEY_IDX_W-1:0];
      found_r   <= hit[KEY_IDX_W];
      empty_r   <= (len == '0);
    end
    if (cmd.apply) begin
      result_r <= result_nxt;
      flag_r   <= flag_nxt;
    end
  end

  assign out_result_byte   = result_r;
  assign out_no_key_letter = flag_r;

endmodule

// ===== hw/rtl/vigenere_letter_cipher.sv =====
`timescale 1ns / 1ps

// Vigenere cipher on a byte stream: each input item carries one text byte and
// yields one result item. Letters are shifted forward (encrypt) or backward
// (decrypt) by the next letter of a repeating key of up to 16 bytes, keeping
// their case; key bytes that are not letters are skipped, and every other text
// byte passes unchanged without using a key letter. A key length of zero passes
// everything through; a key holding no letter passes the byte and sets
// no_key_letter. An item passes through a lookup state, which searches the key
// for the next letter from the stored position, and then an apply state, which
// applies the shift and loads the output register. A new item is taken in the
// cycle its predecessor's result is loaded; a full output register that is not
// being taken holds the block.
// Configuration registers: 0 key_length, 1 decrypt_mode, 2 key bytes 0-7,
// 3 key bytes 8-15 (byte 0 in the lowest bits); write only while idle.
module vigenere_letter_cipher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [vlc_pkg::BYTE_W-1:0]          in_text_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vlc_pkg::BYTE_W-1:0]          out_result_byte,
  output logic                                out_no_key_letter,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vlc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vlc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vlc_pkg::*;

  vlc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  vlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  vlc_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_text_byte      (in_text_byte),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_result_byte   (out_result_byte),
    .out_no_key_letter (out_no_key_letter)
  );

endmodule
